// ===== rtl/light_sphere_scissor_rect_defines.svh =====
// Assertion macros used by light_sphere_scissor_rect.
`ifndef LIGHT_SPHERE_SCISSOR_RECT_DEFINES_SVH
`define LIGHT_SPHERE_SCISSOR_RECT_DEFINES_SVH

// Check while out of reset.
`define LSSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check at every edge, reset included.
`define LSSR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/lssr_pkg.sv =====
package lssr_pkg;

    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int COORD_W   = 32;
    localparam int RANGE_W   = 31;
    localparam int PLANE_W   = 31;
    localparam int VP_W      = 14;
    localparam int PT_W      = 34;
    localparam int MAG_W     = 33;
    localparam int PROD_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR_PLANE      = 3'd0,
        CFG_FAR_PLANE       = 3'd1,
        CFG_PROJ_SCALE_X    = 3'd2,
        CFG_PROJ_SCALE_Y    = 3'd3,
        CFG_VIEWPORT_WIDTH  = 3'd4,
        CFG_VIEWPORT_HEIGHT = 3'd5
    } cfg_reg_t;

    localparam logic [PLANE_W-1:0] NEAR_RST  = 31'd32768;
    localparam logic [PLANE_W-1:0] FAR_RST   = 31'd65536000;
    localparam logic [PLANE_W-1:0] SCALE_RST = 31'd65536;
    localparam logic [VP_W-1:0]    VP_RST    = 14'd1024;

endpackage

// ===== rtl/light_sphere_scissor_rect.sv =====
// Point-light scissor rectangle.
// Input channel s_*: one beat per light, tdata holds center_x, center_y,
// center_z and light_range. Output channel m_*: one beat per light, tdata
// holds rect_top, rect_bottom, rect_left, rect_right in pixels.
// Configuration channel cfg_*: index and data, always ready; write only
// while no light is in flight.
// The restoring divider resolves one quotient bit per stage.
// Throughput: one light per cycle while the receiver accepts; each stage holds its own valid bit.
// A stalled receiver holds the output beat; upstream stages keep filling
// bubbles and s_tready drops only when every stage is full.
// Reset clears all valid bits and loads the register defaults
// (near 0.5, far 1000, scales 1.0, viewport 1024 x 1024).
`include "light_sphere_scissor_rect_defines.svh"
module light_sphere_scissor_rect #(
    parameter int COORD_FRAC_BITS = lssr_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // center_x[31:0], center_y[63:32], center_z[95:64], light_range[126:96]
    input  logic [127:0]                        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // rect_top[13:0], rect_bottom[27:14], rect_left[41:28], rect_right[55:42]
    output logic [55:0]                         m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lssr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lssr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    localparam int NL  = COORD_FRAC_BITS + 7;
    localparam int NST = NL + 1;
    localparam int TW  = lssr_pkg::PT_W;
    localparam int PW  = lssr_pkg::PLANE_W;
    localparam int VW  = lssr_pkg::VP_W;

    logic [PW-1:0] near_reg, far_reg, sx_reg, sy_reg;
    logic [VW-1:0] vw_reg, vh_reg;
    logic [NST-1:0] v_reg;
    logic [NST:0]   rdy;
    logic [lssr_pkg::COORD_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [lssr_pkg::RANGE_W-1:0] r_reg;
    logic signed [TW-1:0] cx, cy, cz, r;
    logic signed [TW-1:0] top_y, bot_y, left_x, right_x, z_p, z_m;
    logic signed [TW-1:0] top_z, bot_z, left_z, right_z;
    logic [VW-1:0] rect_top, rect_bottom, rect_left, rect_right;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_reg <= lssr_pkg::NEAR_RST;
            far_reg  <= lssr_pkg::FAR_RST;
            sx_reg   <= lssr_pkg::SCALE_RST;
            sy_reg   <= lssr_pkg::SCALE_RST;
            vw_reg   <= lssr_pkg::VP_RST;
            vh_reg   <= lssr_pkg::VP_RST;
        end else if (cfg_valid) begin
            case (lssr_pkg::cfg_reg_t'(cfg_index))
                lssr_pkg::CFG_NEAR_PLANE:      near_reg <= cfg_data[PW-1:0];
                lssr_pkg::CFG_FAR_PLANE:       far_reg  <= cfg_data[PW-1:0];
                lssr_pkg::CFG_PROJ_SCALE_X:    sx_reg   <= cfg_data[PW-1:0];
                lssr_pkg::CFG_PROJ_SCALE_Y:    sy_reg   <= cfg_data[PW-1:0];
                lssr_pkg::CFG_VIEWPORT_WIDTH:  vw_reg   <= cfg_data[VW-1:0];
                lssr_pkg::CFG_VIEWPORT_HEIGHT: vh_reg   <= cfg_data[VW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        rdy[NST] = m_tready;
        for (int i = NST - 1; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = v_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < NST; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= (i == 0) ? s_tvalid : v_reg[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            cx_reg <= s_tdata[31:0];
            cy_reg <= s_tdata[63:32];
            cz_reg <= s_tdata[95:64];
            r_reg  <= s_tdata[126:96];
        end
    end

    always_comb begin
        cx = TW'($signed(cx_reg));
        cy = TW'($signed(cy_reg));
        cz = TW'($signed(cz_reg));
        r  = $signed({{(TW-lssr_pkg::RANGE_W){1'b0}}, r_reg});
        top_y   = cy + r;
        bot_y   = cy - r;
        left_x  = cx - r;
        right_x = cx + r;
        z_p     = cz + r;
        z_m     = cz - r;
        top_z   = top_y[TW-1]   ? z_p : z_m;
        bot_z   = bot_y[TW-1]   ? z_m : z_p;
        left_z  = left_x[TW-1]  ? z_m : z_p;
        right_z = right_x[TW-1] ? z_p : z_m;
    end

    lssr_lane #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .NL(NL)) u_top (
        .aclk(aclk), .en(rdy[NST-1:1]), .coord(top_y), .zraw(top_z), .scale(sy_reg),
        .near_plane(near_reg), .far_plane(far_reg), .size(vh_reg), .invert(1'b1),
        .pixel(rect_top)
    );
    lssr_lane #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .NL(NL)) u_bottom (
        .aclk(aclk), .en(rdy[NST-1:1]), .coord(bot_y), .zraw(bot_z), .scale(sy_reg),
        .near_plane(near_reg), .far_plane(far_reg), .size(vh_reg), .invert(1'b1),
        .pixel(rect_bottom)
    );
    lssr_lane #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .NL(NL)) u_left (
        .aclk(aclk), .en(rdy[NST-1:1]), .coord(left_x), .zraw(left_z), .scale(sx_reg),
        .near_plane(near_reg), .far_plane(far_reg), .size(vw_reg), .invert(1'b0),
        .pixel(rect_left)
    );
    lssr_lane #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .NL(NL)) u_right (
        .aclk(aclk), .en(rdy[NST-1:1]), .coord(right_x), .zraw(right_z), .scale(sx_reg),
        .near_plane(near_reg), .far_plane(far_reg), .size(vw_reg), .invert(1'b0),
        .pixel(rect_right)
    );

    assign m_tdata = {rect_right, rect_left, rect_bottom, rect_top};

    `LSSR_ASSERT(a_ready_when_room, (m_tready || !(&v_reg)) |-> s_tready, "stall with room")
    `LSSR_ASSERT(a_rect_in_view, m_tvalid |-> (rect_top <= vh_reg && rect_bottom <= vh_reg && rect_left <= vw_reg && rect_right <= vw_reg), "rect outside viewport")
    `LSSR_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "output valid after reset")
endmodule

// ===== rtl/lssr_lane.sv =====
module lssr_lane #(
    parameter int COORD_FRAC_BITS = lssr_pkg::COORD_FRAC_BITS_DEF,
    parameter int NL = COORD_FRAC_BITS + 7
) (
    input  logic                                 aclk,
    input  logic [NL-1:0]                        en,
    input  logic signed [lssr_pkg::PT_W-1:0]     coord,
    input  logic signed [lssr_pkg::PT_W-1:0]     zraw,
    input  logic [lssr_pkg::PLANE_W-1:0]         scale,
    input  logic [lssr_pkg::PLANE_W-1:0]         near_plane,
    input  logic [lssr_pkg::PLANE_W-1:0]         far_plane,
    input  logic [lssr_pkg::VP_W-1:0]            size,
    input  logic                                 invert,
    output logic [lssr_pkg::VP_W-1:0]            pixel
);
    localparam int Q  = COORD_FRAC_BITS;
    localparam int DS = Q + 2;
    localparam int PW = lssr_pkg::PROD_W;
    localparam int MW = lssr_pkg::MAG_W;
    localparam int ZW = lssr_pkg::PLANE_W;
    localparam int TW = lssr_pkg::PT_W;
    localparam int VW = lssr_pkg::VP_W;
    localparam int OW = Q + 2;
    localparam int XW = OW + VW;
    localparam logic [OW-1:0] ONE = OW'(1) << Q;

    logic signed [TW-1:0] z_lo, z_hi, near_s, far_s;
    logic [ZW-1:0]        dep_next;
    logic [TW-1:0]        mag_full;
    logic [MW-1:0]        s0_mag_reg;
    logic                 s0_neg_reg;
    logic [ZW-1:0]        s0_dep_reg;
    logic [PW-1:0]        s1_prod_reg;
    logic                 s1_neg_reg;
    logic [ZW-1:0]        s1_dep_reg;

    logic [PW-1:0] d_rem [0:DS];
    logic [DS-1:0] d_q   [0:DS];
    logic          d_neg [0:DS];
    logic          d_sat [0:DS];
    logic [ZW-1:0] d_dep [0:DS];

    logic [OW-1:0] qc, offset;
    logic          negp;
    logic [XW-1:0] px_reg;
    logic [XW-Q-2:0] px_sh;
    logic [VW-1:0] pixel_reg;

    always_comb begin
        near_s = $signed({{(TW-ZW){1'b0}}, near_plane});
        far_s  = $signed({{(TW-ZW){1'b0}}, far_plane});
        z_lo   = (zraw < near_s) ? near_s : zraw;
        z_hi   = (z_lo > far_s) ? far_s : z_lo;
        dep_next = (z_hi < $signed(TW'(1))) ? ZW'(1) : z_hi[ZW-1:0];
        mag_full = coord[TW-1] ? TW'(-coord) : TW'(coord);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s0_mag_reg <= mag_full[MW-1:0];
            s0_neg_reg <= coord[TW-1];
            s0_dep_reg <= dep_next;
        end
        if (en[1]) begin
            s1_prod_reg <= PW'({{(PW-MW){1'b0}}, s0_mag_reg} * {{(PW-ZW){1'b0}}, scale});
            s1_neg_reg  <= s0_neg_reg;
            s1_dep_reg  <= s0_dep_reg;
        end
        if (en[2]) begin
            d_rem[0] <= s1_prod_reg;
            d_q[0]   <= '0;
            d_neg[0] <= s1_neg_reg;
            d_sat[0] <= s1_prod_reg >= ({{(PW-ZW){1'b0}}, s1_dep_reg} << DS);
            d_dep[0] <= s1_dep_reg;
        end
    end

    for (genvar j = 0; j < DS; j++) begin : g_div
        localparam int K = DS - 1 - j;
        logic [PW-1:0] trial;
        logic          take;
        assign trial = {{(PW-ZW){1'b0}}, d_dep[j]} << K;
        assign take  = d_rem[j] >= trial;
        always_ff @(posedge aclk) begin
            if (en[3+j]) begin
                d_rem[j+1] <= take ? d_rem[j] - trial : d_rem[j];
                d_q[j+1]   <= d_q[j] | (take ? (DS'(1) << K) : '0);
                d_neg[j+1] <= d_neg[j];
                d_sat[j+1] <= d_sat[j];
                d_dep[j+1] <= d_dep[j];
            end
        end
    end

    always_comb begin
        qc     = (d_sat[DS] || (d_q[DS] > ONE)) ? ONE : d_q[DS];
        negp   = d_neg[DS] ^ invert;
        offset = negp ? ONE - qc : ONE + qc;
        px_sh  = px_reg[XW-1:Q+1];
    end

    always_ff @(posedge aclk) begin
        if (en[Q+5]) begin
            px_reg <= XW'({{VW{1'b0}}, offset} * {{OW{1'b0}}, size});
        end
        if (en[Q+6]) begin
            pixel_reg <= (px_sh > {1'b0, size}) ? size : px_sh[VW-1:0];
        end
    end

    assign pixel = pixel_reg;
endmodule
